// File: hdl/oft_pkg.sv
// ----------------------------------------------------------------------------
// oft_pkg
// Shared widths, codes and reset values of the overcurrent frequency throttle.
// ----------------------------------------------------------------------------
package oft_pkg;

  // Number of frequency levels covered by the tick histogram
  localparam int LEVELS = 32;
  localparam int LVL_AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  localparam int LEVEL_W = 5;
  localparam int TICK_W  = 16;
  localparam int CNT_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = TICK_W;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [TICK_W-1:0]  tick_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [LVL_AW-1:0]  hist_addr_t;
  typedef logic [1:0]         func_t;

  // Transaction function codes
  localparam func_t FUNC_ALARM  = 2'd0;
  localparam func_t FUNC_TICK   = 2'd1;
  localparam func_t FUNC_ENABLE = 2'd2;
  localparam func_t FUNC_READ   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_LEVEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_AFM_LEVEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_STEP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS = 2'd3;

  // Reset values
  localparam level_t TOP_LEVEL_RST     = 5'd31;
  localparam level_t NO_AFM_LEVEL_RST  = 5'd31;
  localparam level_t DOWN_STEP_RST     = 5'd1;
  localparam tick_t  RELEASE_TICKS_RST = 16'd100;

  localparam cnt_t HIST_MAX = '1;

endpackage

// File: hdl/oft_in_if.sv
// ----------------------------------------------------------------------------
// oft_in_if
// Request channel: valid/ready handshake carrying one throttle transaction.
// ----------------------------------------------------------------------------
interface oft_in_if import oft_pkg::*; ();

  logic   valid;
  logic   ready;
  func_t  func;
  logic   cluster_online;
  logic   enable_value;
  level_t read_level;

  modport source (
    output valid,
    output func,
    output cluster_online,
    output enable_value,
    output read_level,
    input  ready
  );

  modport sink (
    input  valid,
    input  func,
    input  cluster_online,
    input  enable_value,
    input  read_level,
    output ready
  );

endinterface

// File: hdl/oft_out_if.sv
// ----------------------------------------------------------------------------
// oft_out_if
// Result channel: valid/ready handshake carrying one throttle status word.
// ----------------------------------------------------------------------------
interface oft_out_if import oft_pkg::*; ();

  logic   valid;
  logic   ready;
  level_t cap_level;
  logic   limited;
  logic   active;
  cnt_t   transitions;
  cnt_t   level_ticks;

  modport source (
    output valid,
    output cap_level,
    output limited,
    output active,
    output transitions,
    output level_ticks,
    input  ready
  );

  modport sink (
    input  valid,
    input  cap_level,
    input  limited,
    input  active,
    input  transitions,
    input  level_ticks,
    output ready
  );

endinterface

// File: hdl/oft_ram.sv
// ----------------------------------------------------------------------------
// oft_ram
// Generic RAM: one write port, two read ports, registered read (old data on
// a read that meets a write to the same address).
// ----------------------------------------------------------------------------
module oft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_a_r;
  logic [WIDTH-1:0] rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a_r <= mem[rd_addr_a];
      rd_data_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

// File: hdl/overcurrent_frequency_throttle_top.sv
// ----------------------------------------------------------------------------
// overcurrent_frequency_throttle_top
// Frequency-cap controller: overcurrent alarms lower the cap level, ticks run
// a release countdown and fill a per-level residency histogram.
// ----------------------------------------------------------------------------
// Pipeline: control update at accept (stage 0), histogram read-modify-write
//   in stage 1, then the result waits in the output register to be taken.
// Throughput: one transaction per cycle while the output is not stalled;
//   the histogram RAM has two read ports and one write port, so each
//   transaction needs one pass through it.
// Reset: synchronous, active low; registers take their documented values and
//   the histogram reads as zero at once through per-level valid bits.
// ----------------------------------------------------------------------------
module overcurrent_frequency_throttle_top import oft_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  oft_in_if.sink                in_ch,
  oft_out_if.source             out_ch
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  level_t top_level_r;
  level_t no_afm_level_r;
  level_t down_step_r;
  tick_t  release_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_level_r     <= TOP_LEVEL_RST;
      no_afm_level_r  <= NO_AFM_LEVEL_RST;
      down_step_r     <= DOWN_STEP_RST;
      release_ticks_r <= RELEASE_TICKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TOP_LEVEL:     top_level_r     <= cfg_data[LEVEL_W-1:0];
        CFG_NO_AFM_LEVEL:  no_afm_level_r  <= cfg_data[LEVEL_W-1:0];
        CFG_DOWN_STEP:     down_step_r     <= cfg_data[LEVEL_W-1:0];
        CFG_RELEASE_TICKS: release_ticks_r <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: stage 1 feeds the output register; the output register is the
  // buffer that lets a new transaction in while a result waits to be taken.
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_fire;
  logic in_fire;

  assign s1_fire      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_fire;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // --------------------------------------------------------------------------
  // Stage 0: scalar control state, updated at accept
  // --------------------------------------------------------------------------
  level_t cap_r,      cap_nxt;
  logic   enabled_r,  enabled_nxt;
  logic   limited_r,  limited_nxt;
  tick_t  rel_r,      rel_nxt;
  cnt_t   chg_r,      chg_nxt;
  logic   hist_inc;

  always_comb begin
    cap_nxt     = cap_r;
    enabled_nxt = enabled_r;
    limited_nxt = limited_r;
    rel_nxt     = rel_r;
    chg_nxt     = chg_r;
    hist_inc    = 1'b0;
    case (in_ch.func)
      FUNC_ALARM: begin
        // Ignore while disabled or with the cluster offline
        if (enabled_r && in_ch.cluster_online) begin
          limited_nxt = 1'b1;
          cap_nxt     = (cap_r >= down_step_r) ? (cap_r - down_step_r) : '0;
          chg_nxt     = chg_r + 1'b1;
          rel_nxt     = release_ticks_r;
        end
      end
      FUNC_TICK: begin
        // Residency counts the cap held before this tick
        hist_inc = enabled_r && (32'(cap_r) < LEVELS);
        if (limited_r) begin
          if (rel_r > tick_t'(1)) begin
            rel_nxt = rel_r - 1'b1;
          end else begin
            // Countdown done: release, restore top level only when online
            rel_nxt     = '0;
            limited_nxt = 1'b0;
            if (in_ch.cluster_online) begin
              cap_nxt = top_level_r;
              chg_nxt = chg_r + 1'b1;
            end
          end
        end
      end
      FUNC_ENABLE: begin
        if ((in_ch.enable_value != enabled_r) && in_ch.cluster_online) begin
          if (in_ch.enable_value) begin
            cap_nxt = top_level_r;
          end else begin
            // Disable: drop any pending release and cap at the no-AFM level
            rel_nxt     = '0;
            limited_nxt = 1'b0;
            cap_nxt     = no_afm_level_r;
          end
          enabled_nxt = in_ch.enable_value;
        end
      end
      FUNC_READ: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= TOP_LEVEL_RST;
      enabled_r <= 1'b1;
      limited_r <= 1'b0;
      rel_r     <= '0;
      chg_r     <= '0;
    end else if (in_fire) begin
      cap_r     <= cap_nxt;
      enabled_r <= enabled_nxt;
      limited_r <= limited_nxt;
      rel_r     <= rel_nxt;
      chg_r     <= chg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 register: post-update status plus histogram addresses
  // --------------------------------------------------------------------------
  level_t     s1_cap_r;
  logic       s1_lim_r;
  logic       s1_act_r;
  cnt_t       s1_chg_r;
  logic       s1_inc_r;
  hist_addr_t s1_inc_addr_r;
  hist_addr_t s1_rd_addr_r;
  logic       s1_rd_ok_r;

  hist_addr_t inc_addr;
  hist_addr_t rd_addr;

  assign inc_addr = LVL_AW'(cap_r);
  assign rd_addr  = LVL_AW'(in_ch.read_level);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cap_r      <= cap_nxt;
      s1_lim_r      <= limited_nxt;
      s1_act_r      <= enabled_nxt;
      s1_chg_r      <= chg_nxt;
      s1_inc_r      <= hist_inc;
      s1_inc_addr_r <= inc_addr;
      s1_rd_addr_r  <= rd_addr;
      s1_rd_ok_r    <= (32'(in_ch.read_level) < LEVELS);
    end
  end

  // --------------------------------------------------------------------------
  // Histogram: RAM plus per-level valid bits (unwritten levels read as zero).
  // The last write is held for forwarding, since a read issued at the edge of
  // that write returns the old word.
  // --------------------------------------------------------------------------
  logic [LEVELS-1:0] hvalid_r;
  logic              wb_valid_r;
  hist_addr_t        wb_addr_r;
  cnt_t              wb_data_r;

  cnt_t ram_a;
  cnt_t ram_b;
  cnt_t a_eff;
  cnt_t b_eff;
  cnt_t inc_val;
  cnt_t ticks_val;
  logic hist_we;

  oft_ram #(
    .WIDTH (CNT_W),
    .DEPTH (LEVELS)
  ) u_hist_ram (
    .clk       (clk),
    .wr_en     (hist_we),
    .wr_addr   (s1_inc_addr_r),
    .wr_data   (inc_val),
    .rd_en     (in_fire),
    .rd_addr_a (inc_addr),
    .rd_addr_b (rd_addr),
    .rd_data_a (ram_a),
    .rd_data_b (ram_b)
  );

  always_comb begin
    if (wb_valid_r && (wb_addr_r == s1_inc_addr_r)) begin
      a_eff = wb_data_r;
    end else if (hvalid_r[s1_inc_addr_r]) begin
      a_eff = ram_a;
    end else begin
      a_eff = '0;
    end

    if (wb_valid_r && (wb_addr_r == s1_rd_addr_r)) begin
      b_eff = wb_data_r;
    end else if (hvalid_r[s1_rd_addr_r]) begin
      b_eff = ram_b;
    end else begin
      b_eff = '0;
    end

    // Saturate at all ones
    inc_val = (a_eff == HIST_MAX) ? a_eff : (a_eff + 1'b1);

    // Report after this transaction's own update
    if (!s1_rd_ok_r) begin
      ticks_val = '0;
    end else if (s1_inc_r && (s1_rd_addr_r == s1_inc_addr_r)) begin
      ticks_val = inc_val;
    end else begin
      ticks_val = b_eff;
    end
  end

  assign hist_we = s1_fire && s1_inc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvalid_r   <= '0;
      wb_valid_r <= 1'b0;
    end else if (hist_we) begin
      hvalid_r[s1_inc_addr_r] <= 1'b1;
      wb_valid_r              <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      wb_addr_r <= s1_inc_addr_r;
      wb_data_r <= inc_val;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  level_t out_cap_r;
  logic   out_lim_r;
  logic   out_act_r;
  cnt_t   out_chg_r;
  cnt_t   out_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_cap_r   <= s1_cap_r;
      out_lim_r   <= s1_lim_r;
      out_act_r   <= s1_act_r;
      out_chg_r   <= s1_chg_r;
      out_ticks_r <= ticks_val;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cap_level   = out_cap_r;
  assign out_ch.limited     = out_lim_r;
  assign out_ch.active      = out_act_r;
  assign out_ch.transitions = out_chg_r;
  assign out_ch.level_ticks = out_ticks_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Throttling can only await release while the operation is enabled
  a_limited_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    limited_r |-> enabled_r)
    else $error("limited flag set while throttling disabled");

  // Transition count moves only with an accepted transaction
  a_chg_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(chg_r))
    else $error("transition count changed without a transaction");

  // A stalled stage-1 transaction is neither lost nor overwritten
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> (s1_valid_r && $stable(s1_chg_r)))
    else $error("stage 1 transaction dropped during stall");

  // Histogram write goes out only with a tick that reached stage 1
  a_hist_we_valid: assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |=> (hvalid_r[$past(s1_inc_addr_r)] && out_valid_r))
    else $error("histogram write without a completed transaction");

endmodule
